@@ sv/psg_pkg.sv @@
package psg_pkg;

  // Fraction bits of the channel counters
  localparam int COUNTER_FRAC_BITS = 8;
  localparam int CntW = 12 + COUNTER_FRAC_BITS;
  localparam int ShUp = (COUNTER_FRAC_BITS >= 8) ? COUNTER_FRAC_BITS - 8 : 0;
  localparam int ShDn = (COUNTER_FRAC_BITS >= 8) ? 0 : 8 - COUNTER_FRAC_BITS;

  typedef logic signed [CntW-1:0] cnt_t;

  // Request codes
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_MASK  = 2'd1;
  localparam logic [1:0] REQ_TICK  = 2'd2;

  // Configuration register indexes
  localparam logic CFG_TICKS  = 1'b0;
  localparam logic CFG_STEREO = 1'b1;

  localparam logic [1:0]  CH_NOISE          = 2'd3;
  localparam logic [1:0]  CH_TONE2          = 2'd2;
  localparam logic [1:0]  RATE_TONE2        = 2'd3;
  localparam logic [9:0]  NOISE_BASE_PERIOD = 10'h010;
  localparam logic [15:0] LFSR_SEED         = 16'h8000;
  localparam logic [11:0] TICKS_RESET       = 12'd1298;

  // Sound register file seen by the channels and the mixer
  typedef struct packed {
    logic [3:0][3:0] att;
    logic [3:0][9:0] period;
    logic            white;
    logic [3:0]      left_mask;
    logic [3:0]      right_mask;
  } psg_regs_t;

  // Quarter-scale amplitude per attenuation step (2 dB)
  function automatic logic [13:0] amp_quarter(input logic [3:0] att);
    logic [13:0] a;
    case (att)
      4'd0:    a = 14'd8191;
      4'd1:    a = 14'd6507;
      4'd2:    a = 14'd5168;
      4'd3:    a = 14'd4105;
      4'd4:    a = 14'd3261;
      4'd5:    a = 14'd2590;
      4'd6:    a = 14'd2057;
      4'd7:    a = 14'd1642;
      4'd8:    a = 14'd1298;
      4'd9:    a = 14'd1031;
      4'd10:   a = 14'd819;
      4'd11:   a = 14'd650;
      4'd12:   a = 14'd516;
      4'd13:   a = 14'd410;
      4'd14:   a = 14'd326;
      default: a = 14'd0;
    endcase
    return a;
  endfunction

  // Align the 4.8 tick step to the counter fraction
  function automatic cnt_t scale_ticks(input logic [11:0] t);
    return (cnt_t'(t) << ShUp) >> ShDn;
  endfunction

endpackage

@@ sv/psg_regs.sv @@
module psg_regs (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_en_i,
  input  logic              mask_en_i,
  input  logic [7:0]        data_i,
  output psg_pkg::psg_regs_t regs_o,
  output logic              noise_load_o
);

  logic [1:0]      latch_ch_q, latch_ch_d;
  logic            latch_vol_q, latch_vol_d;
  logic [3:0][3:0] att_q, att_d;
  logic [3:0][9:0] period_q, period_d;
  logic            white_q, white_d;
  logic [1:0]      rate_q, rate_d;
  logic [3:0]      left_q, left_d;
  logic [3:0]      right_q, right_d;

  // Decode sound register bytes and mask bytes
  always_comb begin
    logic [1:0] ch;
    logic       vol;
    latch_ch_d   = latch_ch_q;
    latch_vol_d  = latch_vol_q;
    att_d        = att_q;
    period_d     = period_q;
    white_d      = white_q;
    rate_d       = rate_q;
    left_d       = left_q;
    right_d      = right_q;
    noise_load_o = 1'b0;
    ch           = latch_ch_q;
    vol          = latch_vol_q;
    if (wr_en_i) begin
      if (data_i[7]) begin
        ch          = data_i[6:5];
        vol         = data_i[4];
        latch_ch_d  = ch;
        latch_vol_d = vol;
      end
      if (vol) begin
        att_d[ch] = data_i[3:0];
      end else if (ch != psg_pkg::CH_NOISE) begin
        if (data_i[7]) begin
          period_d[ch][3:0] = data_i[3:0];
        end else begin
          period_d[ch][9:4] = data_i[5:0];
        end
        if (ch == psg_pkg::CH_TONE2 && rate_q == psg_pkg::RATE_TONE2) begin
          period_d[psg_pkg::CH_NOISE] = period_d[psg_pkg::CH_TONE2];
        end
      end else begin
        white_d      = data_i[2];
        rate_d       = data_i[1:0];
        noise_load_o = 1'b1;
        if (data_i[1:0] == psg_pkg::RATE_TONE2) begin
          period_d[psg_pkg::CH_NOISE] = period_q[psg_pkg::CH_TONE2];
        end else begin
          period_d[psg_pkg::CH_NOISE] = psg_pkg::NOISE_BASE_PERIOD << data_i[1:0];
        end
      end
    end
    if (mask_en_i) begin
      right_d = data_i[3:0];
      left_d  = data_i[7:4];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      latch_ch_q  <= '0;
      latch_vol_q <= 1'b0;
      att_q       <= {4{4'hF}};
      period_q    <= '0;
      white_q     <= 1'b0;
      rate_q      <= '0;
      left_q      <= 4'hF;
      right_q     <= 4'hF;
    end else begin
      latch_ch_q  <= latch_ch_d;
      latch_vol_q <= latch_vol_d;
      att_q       <= att_d;
      period_q    <= period_d;
      white_q     <= white_d;
      rate_q      <= rate_d;
      left_q      <= left_d;
      right_q     <= right_d;
    end
  end

  assign regs_o.att        = att_q;
  assign regs_o.period     = period_q;
  assign regs_o.white      = white_q;
  assign regs_o.left_mask  = left_q;
  assign regs_o.right_mask = right_q;

endmodule

@@ sv/psg_chan.sv @@
module psg_chan (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               tick_i,
  input  logic [9:0]         period_i,
  input  psg_pkg::cnt_t      dec_i,
  input  logic               is_noise_i,
  input  logic               noise_bit_i,
  output logic               level_nxt_o,
  output logic               reload_o
);

  localparam int W = psg_pkg::CntW;

  psg_pkg::cnt_t  cnt_q, cnt_d;
  logic           level_q;
  logic           active;
  logic [W:0]     diff;
  psg_pkg::cnt_t  sat;

  // Step the counter down, clamp at the minimum, reload on zero or below
  always_comb begin
    active   = (period_i[9:1] != '0);
    diff     = {cnt_q[W-1], cnt_q} - {dec_i[W-1], dec_i};
    sat      = (diff[W] != diff[W-1]) ? {1'b1, {(W-1){1'b0}}} : diff[W-1:0];
    reload_o = tick_i && active && (sat[W-1] || sat == '0);
    cnt_d    = cnt_q;
    if (tick_i && active) begin
      cnt_d = sat;
      if (reload_o) begin
        cnt_d = sat + psg_pkg::cnt_t'({period_i, {psg_pkg::COUNTER_FRAC_BITS{1'b0}}});
      end
    end
    level_nxt_o = level_q;
    if (reload_o) begin
      level_nxt_o = is_noise_i ? noise_bit_i : ~level_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      level_q <= 1'b1;
    end else begin
      cnt_q   <= cnt_d;
      level_q <= level_nxt_o;
    end
  end

endmodule

@@ sv/psg_tone_noise_generator.sv @@
// A word is held in the input register, then a tick word's sample is
//   registered with valid; a tick waits while the last sample is stalled.
// Throughput: one word per cycle while no tick word is held by a stall;
//   channel advance and mixing share one pass.
// Reset (async, active low): periods 0, attenuations silent, levels high,
//   noise shift register 0x8000, masks all ones, 1298 ticks per sample, mono.
module psg_tone_noise_generator (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         req_type_i,
  input  logic [7:0]         write_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] left_sample_o,
  output logic signed [15:0] right_sample_o,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [11:0]        cfg_data_i
);

  logic               in_valid_q;
  logic [1:0]         req_q;
  logic [7:0]         data_q;
  logic               out_valid_q;
  logic signed [15:0] left_q, left_d;
  logic signed [15:0] right_q, right_d;
  logic [11:0]        ticks_q;
  logic               stereo_q;
  logic [15:0]        lfsr_q;
  logic               is_tick;
  logic               proc;
  logic               tick;
  logic               noise_load;
  logic [3:0]         level_nxt;
  logic [3:0]         reload;
  psg_pkg::cnt_t      dec;
  psg_pkg::psg_regs_t regs;

  // Handshake: process the held word when its result has room
  assign is_tick    = (req_q == psg_pkg::REQ_TICK);
  assign proc       = in_valid_q && (!is_tick || !out_valid_q || !out_stall_i);
  assign tick       = proc && is_tick;
  assign in_stall_o = in_valid_q && !proc;
  assign dec        = psg_pkg::scale_ticks(ticks_q);

  psg_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wr_en_i      (proc && req_q == psg_pkg::REQ_WRITE),
    .mask_en_i    (proc && req_q == psg_pkg::REQ_MASK),
    .data_i       (data_q),
    .regs_o       (regs),
    .noise_load_o (noise_load)
  );

  for (genvar g = 0; g < 4; g++) begin : g_chan
    psg_chan u_chan (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .tick_i      (tick),
      .period_i    (regs.period[g]),
      .dec_i       (dec),
      .is_noise_i  (g == 3),
      .noise_bit_i (lfsr_q[0]),
      .level_nxt_o (level_nxt[g]),
      .reload_o    (reload[g])
    );
  end

  // Mix the four channels after this tick's advance
  always_comb begin
    logic signed [15:0] s;
    left_d  = '0;
    right_d = '0;
    for (int i = 0; i < 4; i++) begin
      s = $signed({2'b00, psg_pkg::amp_quarter(regs.att[i])});
      if (level_nxt[i]) begin
        s = -s;
      end
      if (!stereo_q) begin
        left_d = left_d + s;
      end else begin
        if (regs.left_mask[i]) begin
          left_d = left_d + s;
        end
        if (regs.right_mask[i]) begin
          right_d = right_d + s;
        end
      end
    end
  end

  // Hold control, configuration and noise shift register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      ticks_q     <= psg_pkg::TICKS_RESET;
      stereo_q    <= 1'b0;
      lfsr_q      <= psg_pkg::LFSR_SEED;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        in_valid_q <= 1'b1;
      end else if (proc) begin
        in_valid_q <= 1'b0;
      end
      if (tick) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          psg_pkg::CFG_TICKS:  ticks_q  <= cfg_data_i;
          psg_pkg::CFG_STEREO: stereo_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (noise_load) begin
        lfsr_q <= psg_pkg::LFSR_SEED;
      end else if (reload[3]) begin
        lfsr_q <= {regs.white ? (lfsr_q[3] ^ lfsr_q[0]) : lfsr_q[0], lfsr_q[15:1]};
      end
    end
  end

  // Capture the input word and the result word
  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      req_q  <= req_type_i;
      data_q <= write_data_i;
    end
    if (tick) begin
      left_q  <= left_d;
      right_q <= right_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign left_sample_o  = left_q;
  assign right_sample_o = right_q;

endmodule

@@ verif/psg_checker.sv @@
`timescale 1ns / 100ps

module psg_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [1:0]         req_type_i,
  input  logic [7:0]         write_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic signed [15:0] left_sample_i,
  input  logic signed [15:0] right_sample_i,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [11:0]        cfg_data_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 checked_o
);

  typedef struct packed {
    logic signed [15:0] left;
    logic signed [15:0] right;
  } sample_t;

  localparam int CntMin = -(1 << (11 + psg_pkg::COUNTER_FRAC_BITS));

  // Shadow copy of the generator state
  logic [11:0] step_ticks;
  logic        stereo_on;
  logic [1:0]  sel_ch;
  logic        sel_att;
  logic [3:0]  att [4];
  logic [9:0]  period [4];
  int          counter [4];
  logic        level [4];
  logic [15:0] lfsr;
  logic        white;
  logic [1:0]  rate;
  logic [3:0]  left_en;
  logic [3:0]  right_en;
  sample_t     sample_q [$];

  // Quarter-scale amplitude, 2 dB per attenuation step
  function automatic int level_amp(input logic [3:0] a);
    int v;
    case (a)
      4'd0:    v = 8191;
      4'd1:    v = 6507;
      4'd2:    v = 5168;
      4'd3:    v = 4105;
      4'd4:    v = 3261;
      4'd5:    v = 2590;
      4'd6:    v = 2057;
      4'd7:    v = 1642;
      4'd8:    v = 1298;
      4'd9:    v = 1031;
      4'd10:   v = 819;
      4'd11:   v = 650;
      4'd12:   v = 516;
      4'd13:   v = 410;
      4'd14:   v = 326;
      default: v = 0;
    endcase
    return v;
  endfunction

  function automatic void reset_state();
    step_ticks = psg_pkg::TICKS_RESET;
    stereo_on  = 1'b0;
    sel_ch     = 2'd0;
    sel_att    = 1'b0;
    for (int i = 0; i < 4; i++) begin
      att[i]     = 4'hF;
      period[i]  = 10'd0;
      counter[i] = 0;
      level[i]   = 1'b1;
    end
    lfsr     = psg_pkg::LFSR_SEED;
    white    = 1'b0;
    rate     = 2'd0;
    left_en  = 4'hF;
    right_en = 4'hF;
  endfunction

  // Noise control: mode, rate and a fresh shift register
  function automatic void load_noise_ctrl(input logic [7:0] v);
    white = v[2];
    rate  = v[1:0];
    lfsr  = psg_pkg::LFSR_SEED;
    if (rate == psg_pkg::RATE_TONE2) period[psg_pkg::CH_NOISE] = period[psg_pkg::CH_TONE2];
    else period[psg_pkg::CH_NOISE] = psg_pkg::NOISE_BASE_PERIOD << rate;
  endfunction

  // Latch or data byte into the sound registers
  function automatic void apply_sound_byte(input logic [7:0] v);
    if (v[7]) begin
      sel_ch  = v[6:5];
      sel_att = v[4];
    end
    if (sel_att) begin
      att[sel_ch] = v[3:0];
    end else if (sel_ch == psg_pkg::CH_NOISE) begin
      load_noise_ctrl(v);
    end else begin
      if (v[7]) period[sel_ch][3:0] = v[3:0];
      else period[sel_ch][9:4] = v[5:0];
      // noise tracks tone 2 at the tone-2 rate
      if (sel_ch == psg_pkg::CH_TONE2 && rate == psg_pkg::RATE_TONE2)
        period[psg_pkg::CH_NOISE] = period[psg_pkg::CH_TONE2];
    end
  endfunction

  // Count one channel down; reload, toggle or shift on wrap
  function automatic void advance_channel(input int ch, input int dec);
    int   c;
    logic fb;
    if (period[ch] < 10'd2) return;
    c = counter[ch] - dec;
    if (c < CntMin) c = CntMin;
    if (c <= 0) begin
      c = c + (int'(period[ch]) << psg_pkg::COUNTER_FRAC_BITS);
      if (ch != int'(psg_pkg::CH_NOISE)) begin
        level[ch] = ~level[ch];
      end else begin
        level[ch] = lfsr[0];
        fb = white ? (lfsr[3] ^ lfsr[0]) : lfsr[0];
        lfsr = {fb, lfsr[15:1]};
      end
    end
    counter[ch] = c;
  endfunction

  // Advance all channels and mix one sample pair
  function automatic sample_t mix_tick();
    int      dec;
    int      l;
    int      r;
    int      s;
    sample_t res;
    dec = (int'(step_ticks) << psg_pkg::ShUp) >> psg_pkg::ShDn;
    l = 0;
    r = 0;
    for (int ch = 0; ch < 4; ch++) begin
      advance_channel(ch, dec);
      s = level_amp(att[ch]);
      if (level[ch]) s = -s;
      if (!stereo_on) begin
        l += s;
      end else begin
        if (left_en[ch]) l += s;
        if (right_en[ch]) r += s;
      end
    end
    res.left  = l[15:0];
    res.right = r[15:0];
    return res;
  endfunction

  // Track writes and words, compare each accepted sample
  always @(posedge clk_i or negedge rst_ni) begin
    sample_t exp_s;
    if (!rst_ni) begin
      reset_state();
      sample_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
      checked_o    = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == psg_pkg::CFG_TICKS) step_ticks = cfg_data_i;
        else stereo_on = cfg_data_i[0];
      end
      if (in_valid_i && !in_stall_i) begin
        case (req_type_i)
          psg_pkg::REQ_WRITE: apply_sound_byte(write_data_i);
          psg_pkg::REQ_MASK: begin
            right_en = write_data_i[3:0];
            left_en  = write_data_i[7:4];
          end
          psg_pkg::REQ_TICK: sample_q.push_back(mix_tick());
          default: ;
        endcase
      end
      if (out_valid_i && !out_stall_i) begin
        if (sample_q.size() == 0) begin
          if (fail_count_o < 10)
            $display("%0t: unexpected sample left %0d right %0d", $realtime,
                     left_sample_i, right_sample_i);
          fail_count_o++;
        end else begin
          exp_s = sample_q.pop_front();
          checked_o++;
          if (exp_s.left !== left_sample_i || exp_s.right !== right_sample_i) begin
            if (fail_count_o < 10)
              $display({"%0t: sample mismatch: expected left %0d right %0d, ",
                        "got left %0d right %0d"},
                       $realtime, exp_s.left, exp_s.right, left_sample_i, right_sample_i);
            fail_count_o++;
          end
        end
      end
      pending_o = sample_q.size();
    end
  end

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int WORD_TARGET = 1650;
  localparam int NUM_PHASES  = 6;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic [1:0]         req_type;
  logic [7:0]         write_data;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic               cfg_we;
  logic               cfg_index;
  logic [11:0]        cfg_data;

  int   fails;
  int   pending;
  int   checked;
  int   words_sent;
  logic no_idle;

  psg_tone_noise_generator u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .req_type_i     (req_type),
    .write_data_i   (write_data),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .left_sample_o  (left_sample),
    .right_sample_o (right_sample),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  psg_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .req_type_i     (req_type),
    .write_data_i   (write_data),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .left_sample_i  (left_sample),
    .right_sample_i (right_sample),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .fail_count_o   (fails),
    .pending_o      (pending),
    .checked_o      (checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Hold off, then present one word until it is taken
  task automatic send_word(input logic [1:0] kind, input logic [7:0] data);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= kind;
    write_data <= data;
    do @(posedge clk); while (in_stall);
    if (kind != REQ_UNUSED) words_sent++;
  endtask

  // Drop valid and wait for every sample, then let writes settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [11:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // One random request or a short well-formed write sequence
  task automatic send_random();
    int         pick;
    logic [1:0] ch;
    logic [7:0] d;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      send_word(psg_pkg::REQ_TICK, 8'($urandom));
    end else if (pick < 68) begin
      // tone period: latch low nibble, mostly follow with a short high part
      ch = 2'($urandom_range(0, 2));
      send_word(psg_pkg::REQ_WRITE, {1'b1, ch, 1'b0, 4'($urandom)});
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 4) == 0) d = {1'b0, 7'($urandom)};
        else d = {1'b0, 5'($urandom), 2'($urandom)} & 8'h43;
        send_word(psg_pkg::REQ_WRITE, d);
      end
    end else if (pick < 80) begin
      ch = 2'($urandom);
      send_word(psg_pkg::REQ_WRITE, {1'b1, ch, 1'b1, 4'($urandom)});
      if ($urandom_range(0, 2) == 0) send_word(psg_pkg::REQ_WRITE, {1'b0, 7'($urandom)});
    end else if (pick < 86) begin
      send_word(psg_pkg::REQ_WRITE, {1'b1, psg_pkg::CH_NOISE, 1'b0, 4'($urandom)});
      if ($urandom_range(0, 2) == 0) send_word(psg_pkg::REQ_WRITE, {1'b0, 7'($urandom)});
    end else if (pick < 93) begin
      send_word(psg_pkg::REQ_MASK, 8'($urandom));
    end else if (pick < 96) begin
      send_word(REQ_UNUSED, 8'($urandom));
    end else begin
      send_word(psg_pkg::REQ_WRITE, 8'($urandom));
    end
  endtask

  // Draw a stall per sample, then take it
  initial begin
    int hold;
    @(posedge rst_n);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 8);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    logic [11:0] tick_set [NUM_PHASES];
    logic        stereo_set [NUM_PHASES];
    int          phase_end;
    in_valid   = 1'b0;
    req_type   = psg_pkg::REQ_TICK;
    write_data = 8'd0;
    out_stall  = 1'b0;
    cfg_we     = 1'b0;
    cfg_index  = psg_pkg::CFG_TICKS;
    cfg_data   = 12'd0;
    no_idle    = 1'b0;
    words_sent = 0;
    rst_n      = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: reset state, extremes, latch and data paths, noise modes
    send_word(psg_pkg::REQ_TICK, 8'h00);
    send_word(psg_pkg::REQ_WRITE, 8'h90);
    send_word(psg_pkg::REQ_WRITE, 8'h82);
    send_word(psg_pkg::REQ_TICK, 8'h00);
    send_word(psg_pkg::REQ_TICK, 8'h00);
    send_word(psg_pkg::REQ_WRITE, 8'h8F);
    send_word(psg_pkg::REQ_WRITE, 8'h3F);
    send_word(psg_pkg::REQ_TICK, 8'h00);
    send_word(psg_pkg::REQ_WRITE, 8'h81);
    send_word(psg_pkg::REQ_WRITE, 8'h00);
    send_word(psg_pkg::REQ_TICK, 8'h00);
    send_word(psg_pkg::REQ_WRITE, 8'hB0);
    send_word(psg_pkg::REQ_WRITE, 8'h05);
    send_word(psg_pkg::REQ_WRITE, 8'hA3);
    send_word(psg_pkg::REQ_WRITE, 8'hC4);
    send_word(psg_pkg::REQ_WRITE, 8'h00);
    send_word(psg_pkg::REQ_WRITE, 8'hE7);
    send_word(psg_pkg::REQ_WRITE, 8'hF0);
    send_word(psg_pkg::REQ_WRITE, 8'hC6);
    send_word(psg_pkg::REQ_TICK, 8'hFF);
    send_word(psg_pkg::REQ_WRITE, 8'hE0);
    send_word(psg_pkg::REQ_WRITE, 8'h03);
    send_word(psg_pkg::REQ_MASK, 8'hA5);
    send_word(REQ_UNUSED, 8'hFF);
    send_word(psg_pkg::REQ_TICK, 8'hFF);
    wait_idle();

    tick_set[0] = psg_pkg::TICKS_RESET; stereo_set[0] = 1'b0;
    tick_set[1] = 12'd4095;             stereo_set[1] = 1'b1;
    tick_set[2] = 12'd256;              stereo_set[2] = 1'b0;
    tick_set[3] = 12'd256;              stereo_set[3] = 1'b1;
    tick_set[4] = 12'd4095;             stereo_set[4] = 1'b0;
    tick_set[5] = 12'($urandom_range(256, 4095));
    stereo_set[5] = 1'($urandom);

    // Random phases, each under its own register setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_cfg(psg_pkg::CFG_TICKS, tick_set[p]);
      write_cfg(psg_pkg::CFG_STEREO, {11'd0, stereo_set[p]});
      no_idle   = (p == 2);
      phase_end = words_sent + WORD_TARGET / NUM_PHASES;
      while (words_sent < phase_end) send_random();
      wait_idle();
    end

    no_idle = 1'b0;
    repeat (8) @(posedge clk);
    $display("Covered %0d words, %0d samples checked, over %0d register settings", words_sent,
             checked, NUM_PHASES);
    $display("Settings spanned tick steps 256 to 4095 in mono and stereo mixes");
    if (fails == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
